// ----- rtl/core/utp_pkg.sv -----
package utp_pkg;

  typedef logic [15:0] char_t;
  typedef logic [63:0] value_t;
  typedef logic [15:0] count_t;
  typedef logic [5:0]  base_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_BAD_BASE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_MINUS  = 3'd1,
    PH_ZERO   = 3'd2,
    PH_ZEROX  = 3'd3,
    PH_DIGITS = 3'd4
  } phase_e;

  localparam base_t  MaxRadix  = 6'd36;
  localparam base_t  BaseOctal = 6'd8;
  localparam base_t  BaseDec   = 6'd10;
  localparam base_t  BaseHex   = 6'd16;
  localparam base_t  NoDigit   = 6'd63;

  localparam char_t  CharMinus  = 16'h002D;
  localparam char_t  CharZero   = 16'h0030;
  localparam char_t  CharNine   = 16'h0039;
  localparam char_t  CharUpperA = 16'h0041;
  localparam char_t  CharUpperZ = 16'h005A;
  localparam char_t  CharLowerA = 16'h0061;
  localparam char_t  CharLowerX = 16'h0078;
  localparam char_t  CharLowerZ = 16'h007A;

  localparam count_t CountMax = 16'hFFFF;
  localparam value_t AllOnes  = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

// ----- rtl/core/utp_char_if.sv -----
interface utp_char_if import utp_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t character;
  logic  start_of_text;

  modport source (output valid, output character, output start_of_text, input ready);
  modport sink   (input valid, input character, input start_of_text, output ready);
endinterface

// ----- rtl/core/utp_result_if.sv -----
interface utp_result_if import utp_pkg::*; ();
  logic    valid;
  logic    ready;
  value_t  parsed_value;
  status_e parse_status;
  count_t  chars_consumed;

  modport source (output valid, output parsed_value, output parse_status,
                  output chars_consumed, input ready);
  modport sink   (input valid, input parsed_value, input parse_status,
                  input chars_consumed, output ready);
endinterface

// ----- rtl/core/utf16_text_to_uint64_parser_core.sv -----
// streaming strtoull-style parser: takes one 16-bit code unit per item on char_i and
// produces one result item on result_o at the character that ends the number (value,
// status, count of characters consumed before it). start_of_text opens a new string and
// latches the base register (2..36, 0 for auto detection of 0x / leading-zero octal);
// a bad base answers on the start character itself. characters outside an open string
// are dropped. one item is taken every cycle while the result register can take it: an input
// register feeds a single step of digit decode, a 64x6 multiply-add with exact overflow check
// and the phase update, and the result lands in an output register, so a result passes
// through the input register and then the output register after its terminating character
// is accepted. the input side stalls only while the result register holds an item that the
// sink has not taken.
module utf16_text_to_uint64_parser_core import utp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  base_t cfg_data_i,
  utp_char_if.sink     char_i,
  utp_result_if.source result_o
);

  // digit value of a code unit, NoDigit when not alphanumeric
  function automatic base_t digit_val(input char_t c);
    base_t v;
    v = NoDigit;
    if (c inside {[CharZero:CharNine]}) begin
      v = base_t'(c - CharZero);
    end else if (c inside {[CharLowerA:CharLowerZ]}) begin
      v = base_t'(c - CharLowerA) + BaseDec;
    end else if (c inside {[CharUpperA:CharUpperZ]}) begin
      v = base_t'(c - CharUpperA) + BaseDec;
    end
    return v;
  endfunction

  function automatic count_t sat_inc(input count_t n);
    return (n == CountMax) ? n : n + 16'd1;
  endfunction

  // configuration
  base_t base_q;

  // input stage
  logic  s1_valid_q;
  char_t s1_char_q;
  logic  s1_start_q;

  // parser state
  phase_e phase_q, phase_d;
  value_t acc_q, acc_d;
  base_t  ab_q, ab_d;
  logic   neg_q, neg_d;
  logic   ovf_q, ovf_d;
  count_t cnt_q, cnt_d;

  // result register
  logic    out_valid_q;
  value_t  out_value_q, out_value_d;
  status_e out_status_q, out_status_d;
  count_t  out_count_q, out_count_d;

  logic   out_free, s1_fire, in_fire, res_load;
  logic   emit, bad_base, step, start_num;
  base_t  dig, minus_base;
  logic [69:0] prod;

  // handshake: the step fires whenever the result register can take a new item
  assign out_free = !out_valid_q || result_o.ready;
  assign s1_fire  = s1_valid_q && out_free;
  assign char_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = char_i.valid && char_i.ready;
  assign res_load = s1_fire && (emit || bad_base);

  assign dig        = digit_val(s1_char_q);
  assign minus_base = (ab_q == '0) ? BaseDec : ab_q;

  // one parser step for the item in the input register
  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    ab_d      = ab_q;
    neg_d     = neg_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    bad_base  = 1'b0;
    step      = 1'b0;
    start_num = 1'b0;
    prod      = '0;

    if (s1_start_q) begin
      // new string: clear and latch the base
      acc_d = '0;
      neg_d = 1'b0;
      ovf_d = 1'b0;
      cnt_d = '0;
      ab_d  = base_q;
      if (base_q == 6'd1 || base_q > MaxRadix) begin
        bad_base = 1'b1;
        phase_d  = PH_IDLE;
      end else if (s1_char_q == CharMinus) begin
        phase_d = PH_MINUS;
      end else begin
        start_num = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_MINUS: begin
          // the sign counts only if a valid digit follows
          if (dig >= minus_base) begin
            emit = 1'b1;
          end else begin
            neg_d     = 1'b1;
            cnt_d     = sat_inc(cnt_q);
            start_num = 1'b1;
          end
        end
        PH_ZERO: begin
          if (s1_char_q == CharLowerX) begin
            phase_d = PH_ZEROX;
          end else begin
            ab_d = (dig < BaseOctal) ? BaseOctal : BaseDec;
            step = 1'b1;
          end
        end
        PH_ZEROX: begin
          if (dig < BaseHex) begin
            ab_d  = BaseHex;
            cnt_d = sat_inc(cnt_q);
            step  = 1'b1;
          end else begin
            ab_d = BaseDec;
            emit = 1'b1;
          end
        end
        PH_DIGITS: begin
          step = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // first character of the number proper
    if (start_num) begin
      if (ab_d == '0) begin
        if (s1_char_q == CharZero) begin
          cnt_d   = sat_inc(cnt_d);
          phase_d = PH_ZERO;
        end else begin
          ab_d = BaseDec;
          step = 1'b1;
        end
      end else begin
        step = 1'b1;
      end
    end

    // accumulate one digit or terminate
    if (step) begin
      if (dig >= ab_d) begin
        emit = 1'b1;
      end else begin
        prod    = 70'(acc_d) * 70'(ab_d) + 70'(dig);
        acc_d   = prod[63:0];
        ovf_d   = ovf_d | (|prod[69:64]);
        cnt_d   = sat_inc(cnt_d);
        phase_d = PH_DIGITS;
      end
    end

    if (emit) begin
      phase_d = PH_IDLE;
    end
  end

  // result formatting
  always_comb begin
    if (bad_base) begin
      out_value_d  = '0;
      out_status_d = STATUS_BAD_BASE;
      out_count_d  = '0;
    end else if (ovf_d) begin
      out_value_d  = AllOnes;
      out_status_d = STATUS_OVERFLOW;
      out_count_d  = cnt_d;
    end else begin
      out_value_d  = neg_d ? (64'd0 - acc_d) : acc_d;
      out_status_d = STATUS_OK;
      out_count_d  = cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      s1_valid_q  <= 1'b0;
      s1_start_q  <= 1'b0;
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      ab_q        <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        s1_start_q <= char_i.start_of_text;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        ab_q    <= ab_d;
        neg_q   <= neg_d;
        ovf_q   <= ovf_d;
        cnt_q   <= cnt_d;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= char_i.character;
    end
    if (res_load) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.parsed_value   = out_value_q;
  assign result_o.parse_status   = out_status_q;
  assign result_o.chars_consumed = out_count_q;

  // a result always closes the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (phase_q == PH_IDLE))
    else $error("phase not idle after result");

  // prefix phases exist only in auto mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ZERO || phase_q == PH_ZEROX) |-> (ab_q == '0))
    else $error("prefix phase with explicit base");

  // bad base answers zero value and zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_BAD_BASE) |->
      (out_value_q == '0 && out_count_q == '0))
    else $error("bad base result not zero");

  // overflow answers all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_OVERFLOW) |-> (out_value_q == AllOnes))
    else $error("overflow result not all ones");

  // input stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !char_i.ready |-> (s1_valid_q && out_valid_q && !result_o.ready))
    else $error("input stalled without cause");

endmodule

// ----- test/utf16_text_to_uint64_parser_core_test.sv -----
`timescale 1ns / 1ps

module utf16_text_to_uint64_parser_core_test;
  import utp_pkg::*;

  localparam int ClkPeriod  = 20;
  localparam int CycleLimit = 600000;
  // enough cycles after the last result for a character that gives no result
  localparam int SettleCycles = 8;

  // one expected result item
  typedef struct packed {
    value_t  value;
    status_e status;
    count_t  count;
  } parse_result_t;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  cfg_we_i;
  base_t cfg_data_i;

  utp_char_if   char_bus ();
  utp_result_if result_bus ();

  utf16_text_to_uint64_parser_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .char_i     (char_bus),
    .result_o   (result_bus)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // parser state as the block should hold it
  base_t   base_reg;
  phase_e  text_phase;
  value_t  acc_value;
  int      cur_radix;
  bit      neg_pending;
  bit      ovf_seen;
  count_t  used_count;

  parse_result_t expected_results[$];

  int fail_count;
  int cycle_count;
  int text_items;
  // percent of cycles the sender idles and the receiver stalls
  int tx_idle_pct;
  int rx_stall_pct;

  // ---------------------------------------------------------------------------
  // parse predictor
  // ---------------------------------------------------------------------------

  // value of c as a digit of radix, -1 when it is not one
  function automatic int digit_value(char_t c, int radix);
    int d;
    d = -1;
    if (c >= CharZero && c <= CharNine) d = int'(c - CharZero);
    else if (c >= CharLowerA && c <= CharLowerZ) d = int'(c - CharLowerA) + 10;
    else if (c >= CharUpperA && c <= CharUpperZ) d = int'(c - CharUpperA) + 10;
    if (d >= radix) d = -1;
    return d;
  endfunction

  function automatic void push_result(value_t v, status_e s, count_t n);
    parse_result_t r;
    r.value  = v;
    r.status = s;
    r.count  = n;
    expected_results.push_back(r);
  endfunction

  // saturating count of consumed characters
  function automatic void bump_count();
    if (used_count != CountMax) used_count = used_count + 16'd1;
  endfunction

  // the terminating character closes the number
  function automatic void emit_number();
    if (ovf_seen) push_result(AllOnes, STATUS_OVERFLOW, used_count);
    else push_result(neg_pending ? value_t'(0) - acc_value : acc_value, STATUS_OK, used_count);
    text_phase = PH_IDLE;
  endfunction

  function automatic void take_digit(char_t c);
    int     d;
    value_t r;
    d = digit_value(c, cur_radix);
    if (d < 0) begin
      emit_number();
      return;
    end
    r = value_t'(cur_radix);
    // exact test for a value above 2^64-1, parsing carries on regardless
    if (acc_value > (AllOnes - value_t'(d)) / r) ovf_seen = 1'b1;
    acc_value = acc_value * r + value_t'(d);
    bump_count();
    text_phase = PH_DIGITS;
  endfunction

  // first character after an optional sign
  function automatic void begin_number(char_t c);
    if (cur_radix == 0) begin
      if (c == CharZero) begin
        bump_count();
        text_phase = PH_ZERO;
        return;
      end
      cur_radix = BaseDec;
    end
    take_digit(c);
  endfunction

  function automatic void predict_parse(char_t c, logic opens);
    if (opens) begin
      acc_value   = '0;
      neg_pending = 1'b0;
      ovf_seen    = 1'b0;
      used_count  = '0;
      cur_radix   = base_reg;
      // a bad base answers on the start character itself
      if (cur_radix == 1 || cur_radix > MaxRadix) begin
        text_phase = PH_IDLE;
        push_result('0, STATUS_BAD_BASE, '0);
        return;
      end
      if (c == CharMinus) begin
        text_phase = PH_MINUS;
        return;
      end
      begin_number(c);
      return;
    end
    case (text_phase)
      PH_MINUS: begin
        // the sign counts only when a digit follows, decimal in auto mode
        if (digit_value(c, (cur_radix != 0) ? cur_radix : int'(BaseDec)) < 0) begin
          emit_number();
        end else begin
          neg_pending = 1'b1;
          bump_count();
          begin_number(c);
        end
      end
      PH_ZERO: begin
        if (c == CharLowerX) begin
          text_phase = PH_ZEROX;
        end else begin
          cur_radix = (digit_value(c, BaseOctal) >= 0) ? int'(BaseOctal) : int'(BaseDec);
          take_digit(c);
        end
      end
      PH_ZEROX: begin
        // the 0x prefix counts only when a hex digit follows
        if (digit_value(c, BaseHex) >= 0) begin
          cur_radix = BaseHex;
          bump_count();
          take_digit(c);
        end else begin
          emit_number();
        end
      end
      PH_DIGITS: take_digit(c);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  function automatic void check_result();
    parse_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result item: value %h status %0d count %0d", $time,
               result_bus.parsed_value, result_bus.parse_status, result_bus.chars_consumed);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    if (result_bus.parsed_value !== want.value) begin
      $display("%0t: parsed_value expected %h actual %h", $time, want.value,
               result_bus.parsed_value);
      fail_count++;
    end
    if (result_bus.parse_status !== want.status) begin
      $display("%0t: parse_status expected %0d actual %0d", $time, want.status,
               result_bus.parse_status);
      fail_count++;
    end
    if (result_bus.chars_consumed !== want.count) begin
      $display("%0t: chars_consumed expected %0d actual %0d", $time, want.count,
               result_bus.chars_consumed);
      fail_count++;
    end
  endfunction

  // results are checked before the new item is predicted: latency keeps them apart
  always @(posedge clk_i) begin
    if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) check_result();
    if (char_bus.valid === 1'b1 && char_bus.ready === 1'b1)
      predict_parse(char_bus.character, char_bus.start_of_text);
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    result_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // send one character item, with random sender gaps ahead of it
  task automatic send_char(char_t c, logic opens);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_bus.valid         <= 1'b1;
    char_bus.character     <= c;
    char_bus.start_of_text <= opens;
    do @(posedge clk_i); while (char_bus.ready !== 1'b1);
  endtask

  // ascii text, start flag on the first character when opens is set
  task automatic send_text(string s, bit opens);
    for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]}, opens && (i == 0));
  endtask

  // drop valid, let every result drain and in-flight characters settle
  task automatic wait_idle();
    char_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_base(base_t v);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    base_reg    = v;
  endtask

  task automatic set_idling(int tx_pct, int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  function automatic char_t rand_char();
    case ($urandom_range(0, 2))
      0: return char_t'($urandom_range(0, 16'hFFFF));
      1: return char_t'($urandom_range(0, 127));
      default: return char_t'($urandom_range(CharMinus, CharLowerZ));
    endcase
  endfunction

  function automatic char_t rand_digit(int radix);
    int v;
    v = $urandom_range(0, radix - 1);
    if (v < 10) return CharZero + char_t'(v);
    if ($urandom_range(0, 1) == 1) return CharLowerA + char_t'(v - 10);
    return CharUpperA + char_t'(v - 10);
  endfunction

  // one random number text in the current base, mostly well formed
  task automatic send_number_text();
    char_t  txt[$];
    int     radix;
    int     ndig;
    int     longest;
    int     pick;
    bit     cut_short;
    value_t rest;
    char_t  c;
    radix     = base_reg;
    cut_short = 1'b0;
    // now and then a string is abandoned by a restart
    if ($urandom_range(0, 19) == 0) begin
      send_char(rand_digit(10), 1'b1);
      send_char(rand_digit(10), 1'b0);
    end
    if (radix == 1 || radix > MaxRadix) begin
      txt.push_back(rand_char());
      cut_short = 1'b1;
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        txt.push_back(CharMinus);
        // broken sign: mostly not followed by a digit
        if ($urandom_range(0, 9) == 0) begin
          txt.push_back(rand_char());
          cut_short = 1'b1;
        end
      end
      if (!cut_short && radix == 0) begin
        case ($urandom_range(0, 4))
          0: begin
            txt.push_back(CharZero);
            txt.push_back(CharLowerX);
            radix = BaseHex;
          end
          1: begin
            txt.push_back(CharZero);
            radix = BaseOctal;
          end
          2: radix = BaseDec;
          3: begin
            // 0x with an arbitrary follower, mostly not hex
            txt.push_back(CharZero);
            txt.push_back(CharLowerX);
            txt.push_back(rand_char());
            cut_short = 1'b1;
          end
          default: begin
            txt.push_back(CharZero);
            txt.push_back(rand_char());
            cut_short = 1'b1;
          end
        endcase
      end
    end
    if (!cut_short) begin
      // digits needed to reach the top of the 64-bit range
      rest    = AllOnes;
      longest = 0;
      while (rest != 0) begin
        rest = rest / value_t'(radix);
        longest++;
      end
      pick = $urandom_range(0, 19);
      if (pick < 12) ndig = $urandom_range(1, 6);
      else if (pick < 17) ndig = $urandom_range(7, 20);
      else ndig = $urandom_range(longest - 1, longest + 2);
      repeat (ndig) txt.push_back(rand_digit(radix));
      do c = rand_char(); while (digit_value(c, radix) >= 0);
      txt.push_back(c);
    end
    foreach (txt[i]) send_char(txt[i], i == 0);
    text_items += txt.size();
    // trailing characters, ignored once the number has closed
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_char(rand_char(), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // auto mode corners with the base at its reset value
  task automatic test_auto_detection();
    send_text("Z", 1'b0);        // character while no string is open
    send_text("-5,", 1'b1);      // negated value wraps
    send_text("--", 1'b1);       // sign without a digit
    send_text("0xfF ", 1'b1);    // hex prefix
    send_text("0xg", 1'b1);      // 0x with no hex digit after it
    send_text("07", 1'b1);       // octal, ended by the top code unit
    send_char(16'hFFFF, 1'b0);
    send_text("09.", 1'b1);      // leading zero but not octal
    send_text("12", 1'b1);       // abandoned by a restart
    send_text("3 ", 1'b1);
    send_text("0X1", 1'b1);      // upper-case X is no prefix
  endtask

  // register extremes, invalid values and explicit radix rules
  task automatic test_base_register();
    write_base(6'd1);
    send_text("AB", 1'b1);       // bad base, the B is ignored
    write_base(6'd63);
    send_text("0", 1'b1);
    write_base(6'd37);
    send_text("z", 1'b1);
    write_base(MaxRadix);
    send_text("zZ", 1'b1);
    send_char(16'h8000, 1'b0);
    write_base(6'd2);
    send_text("-1012", 1'b1);
    write_base(BaseHex);
    send_text("0x1", 1'b1);      // x ends the number in an explicit base
    write_base(BaseOctal);
    send_text("-9", 1'b1);       // sign followed by a digit outside the radix
  endtask

  // values on both sides of 2^64
  task automatic test_overflow_edges();
    write_base(BaseDec);
    send_text("18446744073709551615 ", 1'b1);
    send_text("18446744073709551616 ", 1'b1);
    send_text("-18446744073709551615 ", 1'b1);
    send_text("-99999999999999999999999 ", 1'b1);
    write_base(6'd2);
    send_char(CharZero + 16'd1, 1'b1);
    repeat (63) send_char(CharZero + 16'd1, 1'b0);
    send_char(CharZero + 16'd2, 1'b0);
    send_char(CharZero + 16'd1, 1'b1);
    repeat (64) send_char(CharZero + 16'd1, 1'b0);
    send_text(" ", 1'b0);
    write_base(MaxRadix);
    send_text("3w5e11264sgsf ", 1'b1);
    send_text("3w5e11264sgsg ", 1'b1);
    write_base('0);
    send_text("0xffffffffffffffff ", 1'b1);
    send_text("0x10000000000000000 ", 1'b1);
    send_text("-01777777777777777777777 ", 1'b1);
  endtask

  // random texts across the idling phases, base changed every few dozen items
  task automatic test_random_text();
    int    phase_quota;
    int    since_write;
    base_t b;
    phase_quota = 313;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_idling(0, 0);
        1: set_idling(82, 0);
        2: set_idling(0, 82);
        default: set_idling(12, 12);
      endcase
      text_items  = 0;
      since_write = 1000;
      while (text_items < phase_quota) begin
        if (since_write >= 40) begin
          case ($urandom_range(0, 9))
            0, 1: b = '0;
            2: b = 6'd2;
            3: b = MaxRadix;
            4: b = BaseDec;
            5: b = BaseHex;
            6: b = BaseOctal;
            7: b = base_t'($urandom_range(3, 35));
            8: b = ($urandom_range(0, 1) == 1) ? 6'd1 : base_t'($urandom_range(37, 63));
            default: b = base_t'($urandom_range(2, 36));
          endcase
          write_base(b);
          since_write = text_items;
          since_write = 0;
        end
        pick_and_send(since_write);
      end
    end
  endtask

  // send one random text and account for its items
  task automatic pick_and_send(inout int since_write);
    int before_items;
    before_items = text_items;
    send_number_text();
    since_write += text_items - before_items;
  endtask

  // a run of zeros long enough to saturate the consumed count
  task automatic test_count_saturation();
    set_idling(0, 0);
    write_base(BaseDec);
    send_char(CharZero, 1'b1);
    repeat (65539) send_char(CharZero, 1'b0);
    send_text("7 ", 1'b0);
  endtask

  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_data_i             = '0;
    char_bus.valid         = 1'b0;
    char_bus.character     = '0;
    char_bus.start_of_text = 1'b0;
    result_bus.ready       = 1'b0;
    base_reg               = '0;
    text_phase             = PH_IDLE;
    acc_value              = '0;
    cur_radix              = 0;
    neg_pending            = 1'b0;
    ovf_seen               = 1'b0;
    used_count             = '0;
    fail_count             = 0;
    cycle_count            = 0;
    text_items             = 0;
    set_idling(0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_auto_detection();
    test_base_register();
    test_overflow_edges();
    test_random_text();
    test_count_saturation();

    wait_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
